/* rtl/ske_pkg.sv */
// Shared types, constants and helpers for the super-k-mer k-mer extractor.
// No dependencies; every other file imports this package.
package ske_pkg;

    localparam int KLEN_W           = 5;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 5;
    localparam int REMAIN_W         = 9;
    localparam int ID_W             = 64;
    localparam int QUEUE_DEPTH      = 4;
    localparam int DEF_MAX_KMER_LEN = 31;

    localparam logic [1:0] BASE_COMP = 2'b10;
    localparam logic [1:0] BASE_MASK = 2'h3;

    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ENABLE = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PH_ID    = 2'd0,
        PH_LEN   = 2'd1,
        PH_BASES = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]      byte_val;
        logic [1:0]      last_slot;
        logic            rec_end;
        logic            rec_start;
        logic [ID_W-1:0] id;
    } t_op;

    function automatic logic [KLEN_W-1:0] f_eff_k(
        input logic [KLEN_W-1:0] k,
        input logic [KLEN_W-1:0] kmax
    );
        logic [KLEN_W-1:0] r;
        r = k;
        if (r < KLEN_W'(2)) r = KLEN_W'(2);
        if (r > kmax) r = kmax;
        return r;
    endfunction

endpackage

/* rtl/ske_front.sv */
// Front end: parses record headers and turns each packed base byte into a request.
// Depends on ske_pkg.
module ske_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [7:0]                   i_byte,
    input  logic [ske_pkg::KLEN_W-1:0]   i_k,
    output logic                         o_push,
    output ske_pkg::t_op                 o_op
);
    import ske_pkg::*;

    t_phase               r_phase, n_phase;
    logic [2:0]           r_count, n_count;
    logic [ID_W-1:0]      r_id, n_id;
    logic [REMAIN_W-1:0]  r_remain, n_remain;
    logic                 r_start, n_start;
    logic [1:0]           last_slot;
    logic                 rec_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ID;
            r_count  <= 3'd0;
            r_id     <= '0;
            r_remain <= '0;
            r_start  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_id     <= n_id;
            r_remain <= n_remain;
            r_start  <= n_start;
        end
    end

    always_comb begin
        if (r_remain >= REMAIN_W'(4)) begin
            last_slot = 2'd3;
        end else begin
            last_slot = r_remain[1:0] - 2'd1;
        end
        rec_end = (r_remain <= REMAIN_W'(4));
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_id     = r_id;
        n_remain = r_remain;
        n_start  = r_start;
        o_push   = 1'b0;
        o_op.byte_val  = i_byte;
        o_op.last_slot = last_slot;
        o_op.rec_end   = rec_end;
        o_op.rec_start = r_start;
        o_op.id        = r_id;
        if (i_accept) begin
            case (r_phase)
                PH_LEN: begin
                    n_remain = REMAIN_W'(i_byte) + REMAIN_W'(i_k);
                    n_start  = 1'b1;
                    n_phase  = PH_BASES;
                end
                PH_BASES: begin
                    o_push   = 1'b1;
                    n_start  = 1'b0;
                    n_remain = r_remain - REMAIN_W'({1'b0, last_slot} + 3'd1);
                    if (rec_end) begin
                        n_phase = PH_ID;
                        n_count = 3'd0;
                    end
                end
                default: begin
                    if (r_count == 3'd0) begin
                        n_id = ID_W'(i_byte);
                    end else begin
                        n_id = r_id | (ID_W'(i_byte) << {r_count, 3'b000});
                    end
                    n_count = r_count + 3'd1;
                    n_phase = (r_count == 3'd7) ? PH_LEN : PH_ID;
                end
            endcase
        end
    end

endmodule

/* rtl/ske_queue.sv */
// Short request queue between front and back end, kept as a shift line.
// Depends on ske_pkg.
module ske_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ske_pkg::t_op  i_op,
    input  logic          i_pop,
    output logic          o_valid,
    output ske_pkg::t_op  o_op,
    output logic          o_full
);
    import ske_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_ent [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] wr_pos;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_op    = r_ent[0];
    assign wr_pos  = i_pop ? r_count - CNT_W'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (i_push && (wr_pos == CNT_W'(i))) begin
                r_ent[i] <= i_op;
            end else if (i_pop) begin
                r_ent[i] <= r_ent[i+1];
            end
        end
        if (i_push && (wr_pos == CNT_W'(QUEUE_DEPTH - 1))) begin
            r_ent[QUEUE_DEPTH-1] <= i_op;
        end
    end

endmodule

/* rtl/ske_back.sv */
// Back end: rolls bases into the forward and reverse-complement k-mers and emits results.
// Depends on ske_pkg.
module ske_back #(
    parameter int MAX_KMER_LEN = ske_pkg::DEF_MAX_KMER_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ske_pkg::KLEN_W-1:0]    i_k,
    input  logic                          i_rev_en,
    input  logic                          i_q_valid,
    input  ske_pkg::t_op                  i_q_op,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2*MAX_KMER_LEN-1:0]     o_kmer_value,
    output logic [ske_pkg::ID_W-1:0]      o_source_id,
    output logic                          o_is_reverse,
    output logic                          o_last
);
    import ske_pkg::*;

    localparam int KW = 2 * MAX_KMER_LEN;

    logic              r_busy;
    logic              r_rev_pend;
    logic [7:0]        r_byte;
    logic [1:0]        r_slot;
    logic [1:0]        r_last_slot;
    logic              r_fin;
    logic [ID_W-1:0]   r_id;
    logic [KW-1:0]     r_fwd;
    logic [KW-1:0]     r_rev;
    logic [KLEN_W-1:0] r_held;

    logic              r_out_valid;
    logic [KW-1:0]     r_out_kmer;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_rev;
    logic              r_out_last;

    logic [7:0]        shifted;
    logic [1:0]        base;
    logic [5:0]        mask_sh;
    logic [5:0]        ins_sh;
    logic [KW-1:0]     mask;
    logic [KW-1:0]     n_fwd;
    logic [KW-1:0]     n_rev;
    logic [KLEN_W-1:0] n_held;
    logic              emit;
    logic              fin_base;
    logic              out_free;
    logic              base_go;
    logic              rev_go;
    logic              base_done;
    logic              entry_done;
    logic              load;

    always_comb begin
        shifted  = r_byte << {r_slot, 1'b0};
        base     = shifted[7:6] & BASE_MASK;
        mask_sh  = 6'(KW) - 6'({i_k, 1'b0});
        ins_sh   = 6'({i_k, 1'b0}) - 6'd2;
        mask     = ~(KW'(0)) >> mask_sh;
        n_fwd    = {r_fwd[KW-3:0], base} & mask;
        n_rev    = ((r_rev >> 2) | (KW'(base ^ BASE_COMP) << ins_sh)) & mask;
        n_held   = (r_held < i_k) ? r_held + KLEN_W'(1) : r_held;
        emit     = (n_held >= i_k);
        fin_base = r_fin && (r_slot == r_last_slot);
        out_free = !r_out_valid || !i_out_stall;
        base_go  = r_busy && !r_rev_pend && (!emit || out_free);
        rev_go   = r_busy && r_rev_pend && out_free;
        base_done  = (base_go && !(emit && i_rev_en)) || rev_go;
        entry_done = base_done && (r_slot == r_last_slot);
        load       = i_q_valid && (!r_busy || entry_done);
    end

    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rev_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else begin
            if (base_go && emit) begin
                r_out_valid <= 1'b1;
            end else if (rev_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (base_go && emit && i_rev_en) begin
                r_rev_pend <= 1'b1;
            end else if (rev_go) begin
                r_rev_pend <= 1'b0;
            end
            if (load && i_q_op.rec_start) begin
                r_held <= '0;
            end else if (base_go) begin
                r_held <= n_held;
            end
            if (load) begin
                r_busy <= 1'b1;
            end else if (entry_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (base_go && emit) begin
            r_out_kmer <= n_fwd;
            r_out_id   <= r_id;
            r_out_rev  <= 1'b0;
            r_out_last <= fin_base && !i_rev_en;
        end else if (rev_go) begin
            r_out_kmer <= r_rev;
            r_out_id   <= r_id;
            r_out_rev  <= 1'b1;
            r_out_last <= fin_base;
        end
        if (load && i_q_op.rec_start) begin
            r_fwd <= '0;
            r_rev <= '0;
        end else if (base_go) begin
            r_fwd <= n_fwd;
            r_rev <= n_rev;
        end
        if (load) begin
            r_slot <= 2'd0;
        end else if (base_done && !entry_done) begin
            r_slot <= r_slot + 2'd1;
        end
        if (load) begin
            r_byte      <= i_q_op.byte_val;
            r_last_slot <= i_q_op.last_slot;
            r_fin       <= i_q_op.rec_end;
            r_id        <= i_q_op.id;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kmer_value = r_out_kmer;
    assign o_source_id  = r_out_id;
    assign o_is_reverse = r_out_rev;
    assign o_last       = r_out_last;

endmodule

/* rtl/super_kmer_record_kmer_extractor.sv */
// Top level of the super-k-mer record k-mer extractor: configuration registers,
// front end, request queue and back end. Depends on ske_pkg, ske_front, ske_queue, ske_back.
//
// The front end takes one input byte per cycle; header bytes (eight id bytes, one length
// byte) produce nothing, and every base byte becomes a request in a four-entry queue. The
// back end works through the bases of each request in turn, and with reverse_enable set
// each emitted forward k-mer is followed by its reverse-complement result; that base loop
// sets the sustained rate. Results leave through an output register, one per cycle unless
// i_out_stall holds them, and the front end keeps taking bytes until the queue is full.
module super_kmer_record_kmer_extractor #(
    parameter int MAX_KMER_LEN = ske_pkg::DEF_MAX_KMER_LEN
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_in_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [2*MAX_KMER_LEN-1:0]        o_kmer_value,
    output logic [ske_pkg::ID_W-1:0]         o_source_id,
    output logic                             o_is_reverse,
    output logic                             o_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ske_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ske_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ske_pkg::*;

    logic [KLEN_W-1:0] r_kmer_length;
    logic              r_reverse_enable;
    logic [KLEN_W-1:0] eff_k;
    logic              in_accept;
    logic              push;
    t_op               push_op;
    logic              q_valid;
    t_op               q_op;
    logic              q_pop;
    logic              q_full;

    assign o_cfg_ready = 1'b1;
    assign eff_k       = f_eff_k(r_kmer_length, KLEN_W'(MAX_KMER_LEN));
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length    <= KLEN_W'(31);
            r_reverse_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_KMER_LENGTH) begin
                r_kmer_length <= i_cfg_data[KLEN_W-1:0];
            end else if (i_cfg_index == CFG_REVERSE_ENABLE) begin
                r_reverse_enable <= i_cfg_data[0];
            end
        end
    end

    ske_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .i_k      (eff_k),
        .o_push   (push),
        .o_op     (push_op)
    );

    ske_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op),
        .o_full  (q_full)
    );

    ske_back #(
        .MAX_KMER_LEN (MAX_KMER_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_k          (eff_k),
        .i_rev_en     (r_reverse_enable),
        .i_q_valid    (q_valid),
        .i_q_op       (q_op),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kmer_value (o_kmer_value),
        .o_source_id  (o_source_id),
        .o_is_reverse (o_is_reverse),
        .o_last       (o_last)
    );

endmodule
